/* rtl/core/named_variable_table_core_assert.svh */
// assertion macros for the named variable table checker
// used by nvt_checker.sv only
`ifndef NAMED_VARIABLE_TABLE_CORE_ASSERT_SVH
`define NAMED_VARIABLE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define NVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nvt_pkg.sv */
// shared types and constants of the named variable table
// no dependencies
`timescale 1ns / 1ps

package nvt_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned NAME_CHARS  = 8;
  localparam int unsigned ENTRIES_DEF = 12;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_ACT,
    ST_RES
  } state_e;

  typedef struct packed {
    logic load;
    logic cmp;
    logic enc;
    logic act;
    logic res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

/* rtl/core/nvt_if.sv */
// valid/ready channel interfaces for request and response words
// depends on nvt_pkg
`timescale 1ns / 1ps

interface nvt_req_if;
  logic                               valid;
  logic                               ready;
  logic [nvt_pkg::FUNC_W-1:0]         func;
  logic [nvt_pkg::KEY_W-1:0]          key_name;
  logic signed [nvt_pkg::VAL_W-1:0]   write_value;

  modport source (output valid, output func, output key_name, output write_value,
                  input ready);
  modport sink   (input valid, input func, input key_name, input write_value,
                  output ready);
endinterface

interface nvt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic signed [nvt_pkg::VAL_W-1:0]   read_value;

  modport source (output valid, output ok, output read_value, input ready);
  modport sink   (input valid, input ok, input read_value, output ready);
endinterface

/* rtl/core/named_variable_table_core.sv */
// named variable table: up to ENTRIES 16-bit signed values looked up by name
// response: registered after the key compare, priority encode, registered-read value
// ram and respond steps; the respond step waits while the output register is full
// requests: one at a time, a new request is accepted only when the sequencer is idle
// reset: rst_ni clears all valid bits and the sequencer at once, no clearing pass
`timescale 1ns / 1ps

module named_variable_table_core #(
  parameter int unsigned ENTRIES = nvt_pkg::ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nvt_req_if.sink   req,
  nvt_rsp_if.source rsp
);

  nvt_pkg::ctrl_cmd_t  cmd;
  nvt_pkg::dp_status_t status;

  nvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nvt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (req.func),
    .key_name_i    (req.key_name),
    .write_value_i (req.write_value),
    .rsp_valid_o   (rsp.valid),
    .rsp_ready_i   (rsp.ready),
    .ok_o          (rsp.ok),
    .read_value_o  (rsp.read_value)
  );

endmodule

/* rtl/core/nvt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module nvt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 12,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/nvt_ctrl.sv */
// sequencer for one table operation: compare, encode, access, respond
// depends on nvt_pkg
`timescale 1ns / 1ps

module nvt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  nvt_pkg::dp_status_t    status_i,
  output nvt_pkg::ctrl_cmd_t     cmd_o
);

  nvt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nvt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      nvt_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = nvt_pkg::ST_CMP;
        end
      end
      nvt_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = nvt_pkg::ST_ENC;
      end
      nvt_pkg::ST_ENC: begin
        cmd_o.enc = 1'b1;
        state_d   = nvt_pkg::ST_ACT;
      end
      nvt_pkg::ST_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = nvt_pkg::ST_RES;
      end
      nvt_pkg::ST_RES: begin
        // hold until the output register can take the word
        if (!status_i.out_full) begin
          cmd_o.res = 1'b1;
          state_d   = nvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nvt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/nvt_dp.sv */
// table datapath: key store, parallel compare, priority encode, value ram,
// output register; depends on nvt_pkg and nvt_ram
`timescale 1ns / 1ps

module nvt_dp #(
  parameter int unsigned ENTRIES = nvt_pkg::ENTRIES_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nvt_pkg::ctrl_cmd_t                cmd_i,
  output nvt_pkg::dp_status_t               status_o,
  input  logic [nvt_pkg::FUNC_W-1:0]        func_i,
  input  logic [nvt_pkg::KEY_W-1:0]         key_name_i,
  input  logic signed [nvt_pkg::VAL_W-1:0]  write_value_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output logic                              ok_o,
  output logic signed [nvt_pkg::VAL_W-1:0]  read_value_o
);

  localparam int unsigned KW = nvt_pkg::KEY_W;
  localparam int unsigned VW = nvt_pkg::VAL_W;

  function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] vec);
    logic [IW-1:0] idx;
    idx = '0;
    for (int n = ENTRIES - 1; n >= 0; n--) begin
      if (vec[n]) begin
        idx = IW'(n);
      end
    end
    return idx;
  endfunction

  // name ends at its first zero byte and at NAME_CHARS characters
  logic [KW-1:0] norm_key;
  always_comb begin
    logic alive;
    norm_key = '0;
    alive    = 1'b1;
    for (int p = 0; p < KW / 8; p++) begin
      alive = alive && (key_name_i[p*8 +: 8] != 8'd0) && (p < nvt_pkg::NAME_CHARS);
      if (alive) begin
        norm_key[p*8 +: 8] = key_name_i[p*8 +: 8];
      end
    end
  end

  logic [nvt_pkg::FUNC_W-1:0] op_q;
  logic [KW-1:0]              key_q;
  logic [VW-1:0]              wval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= func_i;
      key_q  <= norm_key;
      wval_q <= write_value_i;
    end
  end

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [KW-1:0]      keys_q [ENTRIES];
  logic [ENTRIES-1:0] match_q, free_q;
  logic               hit_q, room_q;
  logic [IW-1:0]      hit_idx_q, free_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      for (int n = 0; n < ENTRIES; n++) begin
        match_q[n] <= valid_q[n] && (keys_q[n] == key_q);
      end
      free_q <= ~valid_q;
    end
    if (cmd_i.enc) begin
      hit_q      <= |match_q;
      room_q     <= |free_q;
      hit_idx_q  <= first_set(match_q);
      free_idx_q <= first_set(free_q);
    end
  end

  // access step decisions
  logic          key_we;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr;
  logic          ok_d;

  always_comb begin
    valid_d   = valid_q;
    key_we    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hit_idx_q;
    ok_d      = 1'b0;
    if (cmd_i.act) begin
      unique case (nvt_pkg::func_e'(op_q))
        nvt_pkg::FUNC_GET: begin
          ok_d   = hit_q;
          ram_re = hit_q;
        end
        nvt_pkg::FUNC_SET: begin
          if (hit_q) begin
            ram_we = 1'b1;
            ok_d   = 1'b1;
          end else if (room_q) begin
            ram_waddr           = free_idx_q;
            ram_we              = 1'b1;
            key_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            ok_d                = 1'b1;
          end
        end
        nvt_pkg::FUNC_CLEAR: begin
          // stale values stay in ram, unreachable until rewritten
          valid_d = '0;
          ok_d    = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys_q[free_idx_q] <= key_q;
    end
  end

  logic ok_q, rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      ok_q     <= ok_d;
      rd_hit_q <= ram_re;
    end
  end

  logic [VW-1:0] ram_rdata;

  nvt_ram #(
    .WIDTH (VW),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wval_q),
    .re_i    (ram_re),
    .raddr_i (hit_idx_q),
    .rdata_o (ram_rdata)
  );

  // output register
  logic          out_valid_q;
  logic          out_ok_q;
  logic [VW-1:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res) begin
      out_ok_q  <= ok_q;
      out_val_q <= rd_hit_q ? ram_rdata : '0;
    end
  end

  assign status_o.out_full = out_valid_q && !rsp_ready_i;
  assign rsp_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign read_value_o      = out_val_q;

endmodule

/* rtl/core/nvt_checker.sv */
// port-level checks for named_variable_table_core, bound to the top level
// depends on nvt_pkg and named_variable_table_core_assert.svh
`timescale 1ns / 1ps
`include "named_variable_table_core_assert.svh"

module nvt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              rsp_ok_i,
  input logic signed [nvt_pkg::VAL_W-1:0]  rsp_read_value_i
);

  // one request at a time: no new word right after an accept
  `NVT_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request accepted while busy")

  // a stalled response word holds
  `NVT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_ok_i) && $stable(rsp_read_value_i), "response changed under stall")

  // a nonzero value only comes with success
  `NVT_ASSERT_NOW(a_value_ok, clk_i, rst_ni, rsp_valid_i && (rsp_read_value_i != '0), rsp_ok_i, "read value without ok")

endmodule

bind named_variable_table_core nvt_checker u_nvt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_ok_i         (rsp.ok),
  .rsp_read_value_i (rsp.read_value)
);
